// ----- sv/tps_pkg.sv -----
// shared types, constants and register codes for the trapezoidal pulse shaper
// no dependencies; compiled first

package tps_pkg;

  // default values of the top level parameters
  localparam int DELAY_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int RAMP_W     = 10;
  localparam int FLAT_W     = 10;
  localparam int DECAY_W    = 24;
  localparam int RECIP_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 17;
  localparam int INTEG_W    = 48;
  localparam int ACC_W      = 64;
  localparam int SHAPED_W   = 32;
  localparam int FRAC_BITS  = 8;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [RAMP_W-1:0]  RAMP_RST  = 10'd400;
  localparam logic [FLAT_W-1:0]  FLAT_RST  = 10'd180;
  localparam logic [DECAY_W-1:0] DECAY_RST = 24'd0;
  localparam logic [RECIP_W-1:0] RECIP_RST = 32'd10737418;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_LEN    = 2'd0,
    CFG_FLAT_LEN    = 2'd1,
    CFG_DECAY_CONST = 2'd2,
    CFG_NORM_RECIP  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RAMP_W-1:0]  ramp_len;
    logic [FLAT_W-1:0]  flat_len;
    logic [DECAY_W-1:0] decay_const;
    logic [RECIP_W-1:0] norm_recip;
  } cfg_t;

  // per item classification made by the front
  typedef struct packed {
    logic first;
    logic last;
    logic tap1_vld;
    logic tap2_vld;
    logic tap3_vld;
    logic emit;
  } tap_flags_t;

endpackage

// ----- sv/tps_if.sv -----
// channel interfaces of the trapezoidal pulse shaper: sample in, result out, config write
// depends on tps_pkg

interface tps_in_if #(
  parameter int SAMPLE_BITS = tps_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          first;
  logic                          last_in;

  modport source (output valid, output sample, output first, output last_in, input ready);
  modport sink   (input valid, input sample, input first, input last_in, output ready);
endinterface

interface tps_out_if;
  import tps_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SHAPED_W-1:0] shaped;
  logic                       last_out;

  modport source (output valid, output shaped, output last_out, input ready);
  modport sink   (input valid, input shaped, input last_out, output ready);
endinterface

interface tps_cfg_if;
  import tps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/tps_fifo.sv -----
// short queue between the front and the back of the shaper
// depends on tps_pkg

module tps_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);
  import tps_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- sv/tps_front.sv -----
// front of the shaper: accepts samples, tracks waveform position and write pointer,
// works out tap addresses and which taps and results apply; depends on tps_pkg

module tps_front #(
  parameter int DELAY_DEPTH = tps_pkg::DELAY_DEPTH_DEF,
  parameter int PTR_W       = $clog2(DELAY_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tps_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  logic                in_first,
  input  logic                in_last,
  output logic                in_ready,
  input  logic                q_full,
  output logic                q_push,
  output logic [PTR_W-1:0]    tap1_addr,
  output logic [PTR_W-1:0]    tap2_addr,
  output logic [PTR_W-1:0]    tap3_addr,
  output logic [PTR_W-1:0]    wr_addr,
  output tps_pkg::tap_flags_t flags
);
  import tps_pkg::*;

  localparam int DLY_W = (PTR_W + 1 > 12) ? PTR_W + 1 : 12;
  localparam int CMP_W = (COUNT_W > DLY_W) ? COUNT_W : DLY_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] count_cur;
  logic [RAMP_W-1:0]  ramp_eff;
  logic [DLY_W-1:0]   d1_raw, d2_raw, d3_raw;
  logic [DLY_W-1:0]   d1, d2, d3;

  function automatic logic [DLY_W-1:0] clamp_depth(input logic [DLY_W-1:0] d);
    clamp_depth = (d > DLY_W'(DELAY_DEPTH)) ? DLY_W'(DELAY_DEPTH) : d;
  endfunction

  // circular address d places behind the write pointer, d in 1..depth
  function automatic logic [PTR_W-1:0] tap_addr(input logic [PTR_W-1:0] wp,
                                                input logic [DLY_W-1:0] d);
    logic [DLY_W-1:0] base;
    logic [DLY_W-1:0] diff;
    base = (DLY_W'(wp) < d) ? DLY_W'(wp) + DLY_W'(DELAY_DEPTH) : DLY_W'(wp);
    diff = base - d;
    tap_addr = diff[PTR_W-1:0];
  endfunction

  function automatic logic reached(input logic [COUNT_W-1:0] cnt,
                                   input logic [DLY_W-1:0] d);
    reached = (CMP_W'(cnt) >= CMP_W'(d));
  endfunction

  assign ramp_eff = (cfg.ramp_len == '0) ? RAMP_W'(1) : cfg.ramp_len;
  assign d1_raw   = DLY_W'(ramp_eff);
  assign d2_raw   = d1_raw + DLY_W'(cfg.flat_len);
  assign d3_raw   = d2_raw + d1_raw;
  assign d1       = clamp_depth(d1_raw);
  assign d2       = clamp_depth(d2_raw);
  assign d3       = clamp_depth(d3_raw);

  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;
  assign count_cur = in_first ? '0 : count_r;

  assign tap1_addr = tap_addr(wr_ptr_r, d1);
  assign tap2_addr = tap_addr(wr_ptr_r, d2);
  assign tap3_addr = tap_addr(wr_ptr_r, d3);
  assign wr_addr   = wr_ptr_r;

  always_comb begin
    flags.first    = in_first;
    flags.last     = in_last;
    flags.tap1_vld = reached(count_cur, d1);
    flags.tap2_vld = reached(count_cur, d2);
    flags.tap3_vld = reached(count_cur, d3);
    flags.emit     = reached(count_cur, d3);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DELAY_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = (count_cur == COUNT_MAX) ? count_cur : count_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- sv/tps_back.sv -----
// back of the shaper: delay memory, integrator, accumulator and output scaling,
// sequenced one item at a time, with the output register; depends on tps_pkg

module tps_back #(
  parameter int DELAY_DEPTH = tps_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = tps_pkg::SAMPLE_BITS_DEF,
  parameter int PTR_W       = $clog2(DELAY_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tps_pkg::cfg_t                       cfg,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  logic signed [SAMPLE_BITS-1:0]       q_sample,
  input  logic [PTR_W-1:0]                    q_tap1,
  input  logic [PTR_W-1:0]                    q_tap2,
  input  logic [PTR_W-1:0]                    q_tap3,
  input  logic [PTR_W-1:0]                    q_wr,
  input  tps_pkg::tap_flags_t                 q_flags,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tps_pkg::SHAPED_W-1:0] out_shaped,
  output logic                                out_last
);
  import tps_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 2;
  localparam int PROD_W = DECAY_W + 1 + DIFF_W;
  localparam int RND_W  = ACC_W - RECIP_W + 1;
  localparam int HALF_W = ACC_W / 2;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_RD3  = 10'b00_0000_0010,
    ST_DIFF = 10'b00_0000_0100,
    ST_MUL  = 10'b00_0000_1000,
    ST_TERM = 10'b00_0001_0000,
    ST_ACC  = 10'b00_0010_0000,
    ST_MAG  = 10'b00_0100_0000,
    ST_P0   = 10'b00_1000_0000,
    ST_P1   = 10'b01_0000_0000,
    ST_RES  = 10'b10_0000_0000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_a_r, rd_b_r;
  logic                   rd_a_en, rd_b_en, mem_we;
  logic [PTR_W-1:0]       rd_a_addr;

  logic [SAMPLE_BITS-1:0]    x_r;
  logic [SAMPLE_BITS-1:0]    t1_r;
  logic [PTR_W-1:0]          tap3_r, wr_r;
  tap_flags_t                flags_r;
  logic signed [DIFF_W-1:0]  diff_r, diff_nxt;
  logic signed [DIFF_W-1:0]  xe, t1e, t2e, t3e;
  logic [INTEG_W-1:0]        integ_r, integ_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DECAY_W:0]   decay_s;
  logic [ACC_W-1:0]          term_r, term_nxt;
  logic [ACC_W-1:0]          acc_r;
  logic [ACC_W-1:0]          mag_r;
  logic                      neg_r;
  logic [ACC_W-1:0]          p0_r, p1_r;
  logic [RND_W-1:0]          rnd_r;
  logic [ACC_W:0]            rnd_sum;
  logic [ACC_W-1:0]          q_mag;
  logic [SHAPED_W-1:0]       sat_val;
  logic                      out_free;

  logic                      out_valid_r;
  logic signed [SHAPED_W-1:0] shaped_r;
  logic                      last_r;

  assign out_valid  = out_valid_r;
  assign out_shaped = shaped_r;
  assign out_last   = last_r;
  assign out_free   = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    mem_we    = 1'b0;
    rd_a_addr = q_tap1;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          rd_a_en   = 1'b1;
          rd_b_en   = 1'b1;
          state_nxt = ST_RD3;
        end
      end
      ST_RD3: begin
        rd_a_en   = 1'b1;
        rd_a_addr = tap3_r;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        mem_we    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_TERM;
      ST_TERM: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = flags_r.emit ? ST_MAG : ST_IDLE;
      ST_MAG:  state_nxt = ST_P0;
      ST_P0:   state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_RES;
      ST_RES: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // delay memory, two registered read ports and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_r] <= x_r;
    end
    if (rd_a_en) begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_r <= mem[q_tap2];
    end
  end

  // tap difference, taps not yet reached read as zero
  always_comb begin
    xe  = DIFF_W'($signed(x_r));
    t1e = flags_r.tap1_vld ? DIFF_W'($signed(t1_r))   : '0;
    t2e = flags_r.tap2_vld ? DIFF_W'($signed(rd_b_r)) : '0;
    t3e = flags_r.tap3_vld ? DIFF_W'($signed(rd_a_r)) : '0;
    diff_nxt  = xe - t1e - t2e + t3e;
    integ_nxt = (flags_r.first ? '0 : integ_r) + INTEG_W'(diff_nxt);
  end

  assign decay_s = $signed({1'b0, cfg.decay_const});

  always_comb begin
    if (cfg.decay_const != '0) begin
      term_nxt = {{(ACC_W - INTEG_W - FRAC_BITS){integ_r[INTEG_W-1]}}, integ_r,
                  {FRAC_BITS{1'b0}}} + ACC_W'(prod_r);
    end else begin
      term_nxt = {{(ACC_W - DIFF_W - FRAC_BITS){diff_r[DIFF_W-1]}}, diff_r,
                  {FRAC_BITS{1'b0}}};
    end
  end

  // rounding carry of the low partial product and saturation
  assign rnd_sum = {1'b0, p0_r} + (ACC_W + 1)'(64'h8000_0000);
  assign q_mag   = p1_r + ACC_W'(rnd_r);

  always_comb begin
    if (!neg_r) begin
      sat_val = (q_mag > ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_mag[SHAPED_W-1:0];
    end else if (q_mag > ACC_W'(32'h8000_0000)) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = '0 - q_mag[SHAPED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      integ_r     <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIFF) begin
        integ_r <= integ_nxt;
        if (flags_r.first) begin
          acc_r <= '0;
        end
      end
      if (state_r == ST_ACC) begin
        acc_r <= acc_r + term_r;
      end
      if (state_r == ST_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r     <= q_sample;
      tap3_r  <= q_tap3;
      wr_r    <= q_wr;
      flags_r <= q_flags;
    end
    if (state_r == ST_RD3) begin
      t1_r <= rd_a_r;
    end
    if (state_r == ST_DIFF) begin
      diff_r <= diff_nxt;
    end
    if (state_r == ST_MUL) begin
      prod_r <= decay_s * diff_r;
    end
    if (state_r == ST_TERM) begin
      term_r <= term_nxt;
    end
    if (state_r == ST_MAG) begin
      neg_r <= acc_r[ACC_W-1];
      mag_r <= acc_r[ACC_W-1] ? ('0 - acc_r) : acc_r;
    end
    if (state_r == ST_P0) begin
      p0_r <= ACC_W'(mag_r[HALF_W-1:0]) * ACC_W'(cfg.norm_recip);
    end
    if (state_r == ST_P1) begin
      p1_r  <= ACC_W'(mag_r[ACC_W-1:HALF_W]) * ACC_W'(cfg.norm_recip);
      rnd_r <= rnd_sum[ACC_W:ACC_W-RND_W+1];
    end
    if (state_r == ST_RES && out_free) begin
      shaped_r <= $signed(sat_val);
      last_r   <= flags_r.last;
    end
  end

endmodule

// ----- sv/trapezoidal_pulse_shaper.sv -----
// top level of the trapezoidal pulse shaper: config registers, front, queue and back
// depends on tps_pkg, tps_if, tps_front, tps_fifo and tps_back
// sequencing: the back takes one item at a time, popped in IDLE, through RD3, DIFF, MUL, TERM
//   and ACC; an item that gives a result also passes MAG, P0, P1 and RES, and RES waits while
//   out_ch is stalled; the steps follow from three tap reads on a two-read-port delay memory,
//   multiply-accumulate, and the 64x32 gain done as two 32x32 partial products
// reset: synchronous active-low rst_n clears counters, pointers, integrator, accumulator,
//   handshakes and loads the register defaults; the delay memory is not cleared

module trapezoidal_pulse_shaper #(
  parameter int DELAY_DEPTH = tps_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = tps_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tps_in_if.sink       in_ch,
  tps_out_if.source    out_ch,
  tps_cfg_if.sink      cfg_ch
);
  import tps_pkg::*;

  localparam int PTR_W   = $clog2(DELAY_DEPTH);
  localparam int ENTRY_W = SAMPLE_BITS + 4 * PTR_W + $bits(tap_flags_t);

  // configuration registers, writes are always taken
  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_len    <= RAMP_RST;
      cfg_r.flat_len    <= FLAT_RST;
      cfg_r.decay_const <= DECAY_RST;
      cfg_r.norm_recip  <= RECIP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_RAMP_LEN:    cfg_r.ramp_len    <= cfg_ch.data[RAMP_W-1:0];
        CFG_FLAT_LEN:    cfg_r.flat_len    <= cfg_ch.data[FLAT_W-1:0];
        CFG_DECAY_CONST: cfg_r.decay_const <= cfg_ch.data[DECAY_W-1:0];
        CFG_NORM_RECIP:  cfg_r.norm_recip  <= cfg_ch.data[RECIP_W-1:0];
      endcase
    end
  end

  // front: classify each sample against the waveform position
  logic                   q_full, q_push;
  logic [PTR_W-1:0]       f_tap1, f_tap2, f_tap3, f_wr;
  tap_flags_t             f_flags;

  tps_front #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .PTR_W       (PTR_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_first  (in_ch.first),
    .in_last   (in_ch.last_in),
    .in_ready  (in_ch.ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .tap1_addr (f_tap1),
    .tap2_addr (f_tap2),
    .tap3_addr (f_tap3),
    .wr_addr   (f_wr),
    .flags     (f_flags)
  );

  // queue decouples the front from the multi-cycle back
  logic [ENTRY_W-1:0]            q_wdata, q_rdata;
  logic                          q_valid, q_pop;
  logic signed [SAMPLE_BITS-1:0] b_sample;
  logic [PTR_W-1:0]              b_tap1, b_tap2, b_tap3, b_wr;
  tap_flags_t                    b_flags;

  assign q_wdata = {in_ch.sample, f_tap1, f_tap2, f_tap3, f_wr, f_flags};
  assign {b_sample, b_tap1, b_tap2, b_tap3, b_wr, b_flags} = q_rdata;

  tps_fifo #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  // back: filter arithmetic and output register
  tps_back #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PTR_W       (PTR_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_sample   (b_sample),
    .q_tap1     (b_tap1),
    .q_tap2     (b_tap2),
    .q_tap3     (b_tap3),
    .q_wr       (b_wr),
    .q_flags    (b_flags),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_shaped (out_ch.shaped),
    .out_last   (out_ch.last_out)
  );

endmodule

// ----- sv/tps_checker.sv -----
// port-level checks of the trapezoidal pulse shaper, bound to the top level
// depends on tps_pkg and trapezoidal_pulse_shaper

module tps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tps_pkg::SHAPED_W-1:0] out_shaped,
  input logic                         out_last
);
  import tps_pkg::*;

  // set once any sample has been taken since reset
  logic seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      seen_r <= 1'b1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_r)
    else $error("result offered before any item was accepted");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_shaped) && $stable(out_last))
    else $error("result payload changed while stalled");

endmodule

bind trapezoidal_pulse_shaper tps_checker u_tps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_shaped (out_ch.shaped),
  .out_last   (out_ch.last_out)
);
